@@ rtl/baro_temp_pressure_compensation_unit_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers clocked on aclk
// ----------------------------------------------------------------------------
`ifndef BARO_TEMP_PRESSURE_COMPENSATION_UNIT_DEFINES_SVH
`define BARO_TEMP_PRESSURE_COMPENSATION_UNIT_DEFINES_SVH

// check that is off while reset is held
`define BPTC_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// check that holds through reset as well
`define BPTC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

@@ rtl/bptc_pkg.sv @@
// ----------------------------------------------------------------------------
// Compensation package
// Widths, constants and shared types of the compensation pipeline
// ----------------------------------------------------------------------------
package bptc_pkg;

    localparam int RAW_W        = 20;
    localparam int COEF_W       = 16;
    localparam int TFINE_W      = 32;
    localparam int TC_W         = 24;
    localparam int PRESS_W      = 32;
    localparam int CFG_DATA_W   = 64;
    localparam int TFINE_OFFSET = 128000;
    localparam int RAW_FULL     = 1048576;
    localparam int PRESS_SCALE  = 3125;
    localparam int ROUND_HALF   = 128;
    localparam int P4_SHIFT     = 35;
    localparam int ONE_SHIFT    = 47;
    localparam int QUOT_W       = 48;
    localparam int DEN_W        = 41;
    localparam int DIVD_W       = 76;

    typedef enum logic [1:0] {
        REG_TEMP   = 2'd0,
        REG_PLOW   = 2'd1,
        REG_PHIGH  = 2'd2,
        REG_PNINE  = 2'd3
    } bptc_reg_t;

    typedef struct packed {
        logic [COEF_W-1:0] t1, t2, t3;
        logic [COEF_W-1:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
    } bptc_coef_t;

    typedef struct packed {
        logic [TFINE_W-1:0] tfine;
        logic [TC_W-1:0]    tc;
    } bptc_temp_t;

    typedef struct packed {
        bptc_temp_t temp;
        logic       neg;
        logic       den_zero;
    } bptc_side_t;

    typedef struct packed {
        logic [DEN_W-1:0]  rem;
        logic [QUOT_W-1:0] dvd_lo;
        logic [QUOT_W-1:0] quot;
        logic [DEN_W-1:0]  den;
        logic              ovf;
        bptc_side_t        side;
    } bptc_div_t;

endpackage

@@ rtl/bptc_front.sv @@
// ----------------------------------------------------------------------------
// Compensation front end
// Temperature path, pressure divisor and dividend, twelve register stages
// ----------------------------------------------------------------------------
module bptc_front
    import bptc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              adv,
    input  bptc_coef_t        coef,
    input  logic              in_valid,
    input  logic [RAW_W-1:0]  raw_temperature,
    input  logic [RAW_W-1:0]  raw_pressure,
    output logic              out_valid,
    output bptc_div_t         out_data
);

    localparam int FRONT_DEPTH = 12;

    logic [FRONT_DEPTH-1:0] vld_reg;

    logic signed [18:0] ta_diff;
    logic signed [17:0] td;
    logic signed [34:0] ta_prod_reg, ta_prod_next;
    logic signed [35:0] td_sq_reg, td_sq_next;
    logic [RAW_W-1:0]   rp1_reg, rp2_reg, rp3_reg, rp4_reg, rp5_reg, rp6_reg, rp7_reg;

    logic signed [23:0] tva_reg, tva_next;
    logic signed [23:0] tsq_sh;
    logic signed [39:0] tvb_reg, tvb_next;

    logic signed [TFINE_W-1:0] tfine3_reg, tfine3_next;

    logic signed [35:0] tc_wide;
    logic signed [31:0] pva_wide;
    bptc_temp_t         temp4_reg, temp4_next;
    logic signed [23:0] pva_reg, pva_next;

    bptc_temp_t         temp5_reg, temp6_reg, temp7_reg, temp8_reg, temp9_reg;
    bptc_temp_t         temp10_reg, temp11_reg;
    logic signed [47:0] vsq_reg, vsq_next;
    logic signed [39:0] pv5_reg, pv5_next, pv2_reg, pv2_next;
    logic signed [39:0] pv5b_reg, pv2b_reg;

    logic signed [63:0] vb6_reg, vb6_next, vs3_reg, vs3_next;

    logic signed [63:0] vbv_reg, vbv_next;
    logic signed [56:0] base_reg, base_next;

    logic [20:0]        pgap;
    logic signed [45:0] pl_reg, pl_next, ph_reg, ph_next;
    logic signed [64:0] num8_reg, num8_next;

    logic signed [74:0] den_prod;
    logic signed [41:0] va3_reg, va3_next;
    logic signed [64:0] num9_reg;

    logic signed [64:0] num_abs;
    logic signed [41:0] va3_abs;
    logic               neg10_reg, neg10_next, dz10_reg, dz10_next;
    logic [63:0]        un_reg, un_next;
    logic [DEN_W-1:0]   ud10_reg, ud10_next;

    logic               neg11_reg, dz11_reg;
    logic [DIVD_W-1:0]  x_reg, x_next;
    logic [DEN_W-1:0]   ud11_reg;

    bptc_div_t          out_reg, out_next;

    always_comb begin
        // temperature
        ta_diff = $signed({2'b00, raw_temperature[RAW_W-1:3]})
                - $signed({2'b00, coef.t1, 1'b0});
        td      = $signed({2'b00, raw_temperature[RAW_W-1:4]}) - $signed({2'b00, coef.t1});
        ta_prod_next = ta_diff * $signed(coef.t2);
        td_sq_next   = td * td;

        tsq_sh   = $signed(td_sq_reg[35:12]);
        tvb_next = tsq_sh * $signed(coef.t3);
        tva_next = $signed(ta_prod_reg[34:11]);

        tfine3_next = tva_reg + $signed(tvb_reg[39:14]);

        tc_wide          = tfine3_reg * 5 + ROUND_HALF;
        temp4_next.tfine = tfine3_reg;
        temp4_next.tc    = tc_wide[31:8];
        pva_wide         = tfine3_reg - TFINE_OFFSET;
        pva_next         = $signed(pva_wide[23:0]);

        // pressure divisor and dividend
        vsq_next = pva_reg * pva_reg;
        pv5_next = pva_reg * $signed(coef.p5);
        pv2_next = pva_reg * $signed(coef.p2);

        vb6_next = vsq_reg * $signed(coef.p6);
        vs3_next = vsq_reg * $signed(coef.p3);

        vbv_next  = vb6_reg + $signed({pv5b_reg, 17'b0})
                  + $signed({coef.p4, {P4_SHIFT{1'b0}}});
        base_next = $signed(vs3_reg[63:8]) + $signed({pv2b_reg, 12'b0})
                  + $signed({2'b01, {ONE_SHIFT{1'b0}}});

        pgap      = 21'(RAW_FULL) - {1'b0, rp7_reg};
        pl_next   = $signed({1'b0, base_reg[27:0]}) * $signed({1'b0, coef.p1});
        ph_next   = $signed(base_reg[56:28]) * $signed({1'b0, coef.p1});
        num8_next = $signed({1'b0, pgap, 31'b0}) - vbv_reg;

        den_prod  = $signed({ph_reg, 28'b0}) + pl_reg;
        va3_next  = $signed(den_prod[74:33]);

        num_abs    = num9_reg[64] ? -num9_reg : num9_reg;
        va3_abs    = va3_reg[41] ? -va3_reg : va3_reg;
        neg10_next = num9_reg[64] ^ va3_reg[41];
        dz10_next  = (va3_reg == '0);
        un_next    = num_abs[63:0];
        ud10_next  = va3_abs[DEN_W-1:0];

        x_next = {12'b0, un_reg} * DIVD_W'(PRESS_SCALE);

        out_next.rem           = DEN_W'(x_reg[DIVD_W-1:QUOT_W]);
        out_next.dvd_lo        = x_reg[QUOT_W-1:0];
        out_next.quot          = '0;
        out_next.den           = ud11_reg;
        out_next.ovf           = DEN_W'(x_reg[DIVD_W-1:QUOT_W]) >= ud11_reg;
        out_next.side.temp     = temp11_reg;
        out_next.side.neg      = neg11_reg;
        out_next.side.den_zero = dz11_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[FRONT_DEPTH-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            ta_prod_reg <= ta_prod_next;
            td_sq_reg   <= td_sq_next;
            rp1_reg     <= raw_pressure;
            tva_reg     <= tva_next;
            tvb_reg     <= tvb_next;
            rp2_reg     <= rp1_reg;
            tfine3_reg  <= tfine3_next;
            rp3_reg     <= rp2_reg;
            temp4_reg   <= temp4_next;
            pva_reg     <= pva_next;
            rp4_reg     <= rp3_reg;
            temp5_reg   <= temp4_reg;
            vsq_reg     <= vsq_next;
            pv5_reg     <= pv5_next;
            pv2_reg     <= pv2_next;
            rp5_reg     <= rp4_reg;
            temp6_reg   <= temp5_reg;
            vb6_reg     <= vb6_next;
            vs3_reg     <= vs3_next;
            pv5b_reg    <= pv5_reg;
            pv2b_reg    <= pv2_reg;
            rp6_reg     <= rp5_reg;
            temp7_reg   <= temp6_reg;
            vbv_reg     <= vbv_next;
            base_reg    <= base_next;
            rp7_reg     <= rp6_reg;
            temp8_reg   <= temp7_reg;
            pl_reg      <= pl_next;
            ph_reg      <= ph_next;
            num8_reg    <= num8_next;
            temp9_reg   <= temp8_reg;
            va3_reg     <= va3_next;
            num9_reg    <= num8_reg;
            temp10_reg  <= temp9_reg;
            neg10_reg   <= neg10_next;
            dz10_reg    <= dz10_next;
            un_reg      <= un_next;
            ud10_reg    <= ud10_next;
            temp11_reg  <= temp10_reg;
            neg11_reg   <= neg10_reg;
            dz11_reg    <= dz10_reg;
            x_reg       <= x_next;
            ud11_reg    <= ud10_reg;
            out_reg     <= out_next;
        end
    end

    assign out_valid = vld_reg[FRONT_DEPTH-1];
    assign out_data  = out_reg;

endmodule

@@ rtl/bptc_div_step.sv @@
// ----------------------------------------------------------------------------
// Division step
// One registered restoring step, one quotient bit per stage
// ----------------------------------------------------------------------------
module bptc_div_step
    import bptc_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      adv,
    input  logic      in_valid,
    input  bptc_div_t in_data,
    output logic      out_valid,
    output bptc_div_t out_data
);

    logic [DEN_W:0] trial;
    logic [DEN_W:0] diff;
    logic           fits;
    logic           vld_reg;
    bptc_div_t      stage_reg, stage_next;

    always_comb begin
        trial = {in_data.rem, in_data.dvd_lo[QUOT_W-1]};
        diff  = trial - {1'b0, in_data.den};
        fits  = trial >= {1'b0, in_data.den};
        stage_next        = in_data;
        stage_next.rem    = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        stage_next.dvd_lo = {in_data.dvd_lo[QUOT_W-2:0], 1'b0};
        stage_next.quot   = {in_data.quot[QUOT_W-2:0], fits};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (adv) begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            stage_reg <= stage_next;
        end
    end

    assign out_valid = vld_reg;
    assign out_data  = stage_reg;

endmodule

@@ rtl/bptc_back.sv @@
// ----------------------------------------------------------------------------
// Compensation back end
// Quotient limit, second-order pressure correction and output register
// ----------------------------------------------------------------------------
`include "baro_temp_pressure_compensation_unit_defines.svh"

module bptc_back
    import bptc_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      adv,
    input  bptc_coef_t                coef,
    input  logic                      in_valid,
    input  bptc_div_t                 in_data,
    output logic                      out_valid,
    output logic signed [TFINE_W-1:0] out_fine_temperature,
    output logic signed [TC_W-1:0]    out_temperature_centi,
    output logic [PRESS_W-1:0]        out_pressure_q24_8,
    output logic                      out_pressure_valid
);

    localparam int BACK_DEPTH = 7;

    logic [BACK_DEPTH-1:0] vld_reg;

    logic [QUOT_W-1:0]  cap;
    logic [QUOT_W-1:0]  mag;
    logic signed [48:0] pr1_reg, pr1_next, pr2_reg, pr3_reg, pr4_reg, pr5_reg;
    bptc_side_t         side1_reg, side2_reg, side3_reg, side4_reg, side5_reg, side6_reg;

    logic signed [35:0] s_val;
    logic signed [35:0] hh_reg, hh_next;
    logic signed [36:0] hl_reg, hl_next;
    logic [35:0]        ll_reg, ll_next;
    logic signed [41:0] c8l_reg, c8l_next;
    logic signed [39:0] c8h_reg, c8h_next;

    logic signed [71:0] sq_full;
    logic signed [65:0] c8_full;
    logic [68:0]        sq_reg, sq_next;
    logic signed [46:0] c8_3_reg, c8_3_next, c8_4_reg, c8_5_reg;

    logic signed [39:0] m0_reg, m0_next, m1_reg, m1_next, m2_reg, m2_next;

    logic signed [86:0] prod9;
    logic signed [61:0] c9_reg, c9_next;

    logic signed [63:0] psum;
    logic signed [56:0] pre_reg, pre_next;

    logic [PRESS_W-1:0]        press_clamped;
    logic signed [TFINE_W-1:0] fine_reg;
    logic signed [TC_W-1:0]    tc_reg;
    logic [PRESS_W-1:0]        press_reg, press_next;
    logic                      pvalid_reg;

    always_comb begin
        cap      = {1'b1, {(QUOT_W-1){1'b0}}};
        mag      = (in_data.ovf || in_data.quot > cap) ? cap : in_data.quot;
        pr1_next = in_data.side.neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

        s_val    = $signed(pr1_reg[48:13]);
        hh_next  = $signed(s_val[35:18]) * $signed(s_val[35:18]);
        hl_next  = $signed(s_val[35:18]) * $signed({1'b0, s_val[17:0]});
        ll_next  = {18'b0, s_val[17:0]} * {18'b0, s_val[17:0]};
        c8l_next = $signed({1'b0, pr1_reg[24:0]}) * $signed(coef.p8);
        c8h_next = $signed(pr1_reg[48:25]) * $signed(coef.p8);

        sq_full   = $signed({hh_reg, 36'b0}) + $signed({hl_reg, 19'b0})
                  + $signed({1'b0, ll_reg});
        sq_next   = sq_full[68:0];
        c8_full   = $signed({c8h_reg, 25'b0}) + c8l_reg;
        c8_3_next = $signed(c8_full[65:19]);

        m0_next = $signed({1'b0, sq_reg[22:0]}) * $signed(coef.p9);
        m1_next = $signed({1'b0, sq_reg[45:23]}) * $signed(coef.p9);
        m2_next = $signed({1'b0, sq_reg[68:46]}) * $signed(coef.p9);

        prod9   = $signed({m2_reg, 46'b0}) + $signed({m1_reg, 23'b0}) + m0_reg;
        c9_next = $signed(prod9[86:25]);

        psum     = pr5_reg + c9_reg + c8_5_reg;
        pre_next = $signed(psum[63:8]) + $signed({coef.p7, 4'b0});

        if (pre_reg[56]) begin
            press_clamped = '0;
        end else if (|pre_reg[55:PRESS_W]) begin
            press_clamped = '1;
        end else begin
            press_clamped = pre_reg[PRESS_W-1:0];
        end
        press_next = side6_reg.den_zero ? '0 : press_clamped;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[BACK_DEPTH-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            pr1_reg    <= pr1_next;
            side1_reg  <= in_data.side;
            hh_reg     <= hh_next;
            hl_reg     <= hl_next;
            ll_reg     <= ll_next;
            c8l_reg    <= c8l_next;
            c8h_reg    <= c8h_next;
            pr2_reg    <= pr1_reg;
            side2_reg  <= side1_reg;
            sq_reg     <= sq_next;
            c8_3_reg   <= c8_3_next;
            pr3_reg    <= pr2_reg;
            side3_reg  <= side2_reg;
            m0_reg     <= m0_next;
            m1_reg     <= m1_next;
            m2_reg     <= m2_next;
            c8_4_reg   <= c8_3_reg;
            pr4_reg    <= pr3_reg;
            side4_reg  <= side3_reg;
            c9_reg     <= c9_next;
            c8_5_reg   <= c8_4_reg;
            pr5_reg    <= pr4_reg;
            side5_reg  <= side4_reg;
            pre_reg    <= pre_next;
            side6_reg  <= side5_reg;
            fine_reg   <= $signed(side6_reg.temp.tfine);
            tc_reg     <= $signed(side6_reg.temp.tc);
            press_reg  <= press_next;
            pvalid_reg <= !side6_reg.den_zero;
        end
    end

    assign out_valid             = vld_reg[BACK_DEPTH-1];
    assign out_fine_temperature  = fine_reg;
    assign out_temperature_centi = tc_reg;
    assign out_pressure_q24_8    = press_reg;
    assign out_pressure_valid    = pvalid_reg;

    `BPTC_ASSERT_RST(a_stall_holds, !adv |=> $stable(vld_reg), "pipeline moved during stall")
    `BPTC_ASSERT_RST(a_last_moves, adv && vld_reg[BACK_DEPTH-2] |=> vld_reg[BACK_DEPTH-1], "item lost at output register")
    `BPTC_ASSERT_RST(a_invalid_zero, out_valid && !out_pressure_valid |-> out_pressure_q24_8 == '0, "invalid pressure not zero")

endmodule

@@ rtl/baro_temp_pressure_compensation_unit.sv @@
// ----------------------------------------------------------------------------
// Barometric temperature and pressure compensation unit
// Integer compensation of raw 20-bit readings with 64-bit exact arithmetic
// ----------------------------------------------------------------------------
// One reading pair enters per clock unless stalled, and passes through 12
// stages of temperature and divisor arithmetic, 48 stages of a restoring
// divider that produce one quotient bit each, and 7 stages of pressure
// correction ending in the output register. The whole pipeline advances on a
// common enable, so a stall on the result side freezes every stage and s_ready
// follows it. The user writes calibration registers through the cfg port only
// while no transaction is in flight (unchecked); writes are taken every cycle.
module baro_temp_pressure_compensation_unit
    import bptc_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,

    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [1:0]                cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data,

    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [RAW_W-1:0]          s_raw_temperature,
    input  logic [RAW_W-1:0]          s_raw_pressure,

    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [TFINE_W-1:0] m_fine_temperature,
    output logic signed [TC_W-1:0]    m_temperature_centi,
    output logic [PRESS_W-1:0]        m_pressure_q24_8,
    output logic                      m_pressure_valid
);

    logic [47:0]          temp_coeffs_reg;
    logic [63:0]          press_low_reg;
    logic [63:0]          press_high_reg;
    logic [COEF_W-1:0]    press_nine_reg;
    bptc_coef_t           coef;
    logic                 adv;

    logic [QUOT_W:0]      div_vld;
    bptc_div_t            div_data [0:QUOT_W];

    assign cfg_ready = 1'b1;
    assign adv       = !m_valid || m_ready;
    assign s_ready   = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            temp_coeffs_reg <= '0;
            press_low_reg   <= '0;
            press_high_reg  <= '0;
            press_nine_reg  <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (bptc_reg_t'(cfg_index))
                REG_TEMP:  temp_coeffs_reg <= cfg_data[47:0];
                REG_PLOW:  press_low_reg   <= cfg_data;
                REG_PHIGH: press_high_reg  <= cfg_data;
                REG_PNINE: press_nine_reg  <= cfg_data[COEF_W-1:0];
                default:   press_nine_reg  <= press_nine_reg;
            endcase
        end
    end

    always_comb begin
        coef.t1 = temp_coeffs_reg[15:0];
        coef.t2 = temp_coeffs_reg[31:16];
        coef.t3 = temp_coeffs_reg[47:32];
        coef.p1 = press_low_reg[15:0];
        coef.p2 = press_low_reg[31:16];
        coef.p3 = press_low_reg[47:32];
        coef.p4 = press_low_reg[63:48];
        coef.p5 = press_high_reg[15:0];
        coef.p6 = press_high_reg[31:16];
        coef.p7 = press_high_reg[47:32];
        coef.p8 = press_high_reg[63:48];
        coef.p9 = press_nine_reg;
    end

    bptc_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .adv             (adv),
        .coef            (coef),
        .in_valid        (s_valid),
        .raw_temperature (s_raw_temperature),
        .raw_pressure    (s_raw_pressure),
        .out_valid       (div_vld[0]),
        .out_data        (div_data[0])
    );

    for (genvar i = 0; i < QUOT_W; i++) begin : g_div
        bptc_div_step u_step (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .adv       (adv),
            .in_valid  (div_vld[i]),
            .in_data   (div_data[i]),
            .out_valid (div_vld[i+1]),
            .out_data  (div_data[i+1])
        );
    end

    bptc_back u_back (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .adv                   (adv),
        .coef                  (coef),
        .in_valid              (div_vld[QUOT_W]),
        .in_data               (div_data[QUOT_W]),
        .out_valid             (m_valid),
        .out_fine_temperature  (m_fine_temperature),
        .out_temperature_centi (m_temperature_centi),
        .out_pressure_q24_8    (m_pressure_q24_8),
        .out_pressure_valid    (m_pressure_valid)
    );

endmodule

@@ tb/sv/baro_temp_pressure_compensation_unit_tb.sv @@
// ----------------------------------------------------------------------------
// Compensation unit testbench
// Drives raw reading pairs and calibration writes, predicts each result with
// an exact wide-integer compensation model and checks it field by field
// ----------------------------------------------------------------------------
module baro_temp_pressure_compensation_unit_tb;
    import bptc_pkg::*;

    typedef logic signed [127:0] wide_t;

    typedef struct {
        logic [TFINE_W-1:0] fine;
        logic [TC_W-1:0]    centi;
        logic [PRESS_W-1:0] press;
        logic               press_ok;
    } comp_result_t;

    class comp_scoreboard;
        logic [47:0]    temp_coeffs;
        logic [63:0]    press_low;
        logic [63:0]    press_high;
        logic [15:0]    press_nine;
        comp_result_t   expected_q[$];
        int             errors;

        function new();
            temp_coeffs = '0;
            press_low   = '0;
            press_high  = '0;
            press_nine  = '0;
            errors      = 0;
        endfunction

        function void set_register(bptc_reg_t idx, logic [63:0] data);
            case (idx)
                REG_TEMP:  temp_coeffs = data[47:0];
                REG_PLOW:  press_low   = data;
                REG_PHIGH: press_high  = data;
                REG_PNINE: press_nine  = data[15:0];
                default: ;
            endcase
        endfunction

        function wide_t sx16(logic [15:0] v);
            wide_t r;
            r = $signed(v);
            return r;
        endfunction

        function wide_t clamp(wide_t x, wide_t lo, wide_t hi);
            return x < lo ? lo : (x > hi ? hi : x);
        endfunction

        function wide_t mul_floor_sat(wide_t a, wide_t b, int n);
            wide_t p;
            p = (a * b) >>> n;
            return clamp(p, -(wide_t'(1) <<< 63), (wide_t'(1) <<< 63) - 1);
        endfunction

        function void note_reading(logic [RAW_W-1:0] raw_t, logic [RAW_W-1:0] raw_p);
            wide_t adc_t, adc_p, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
            wide_t va, vb, d, tfine, tc, pr, num, s, c9, c8;
            logic [127:0] un, ud, q1, r1, mag;
            logic neg;
            comp_result_t res;
            adc_t = {108'b0, raw_t};
            adc_p = {108'b0, raw_p};
            t1 = {112'b0, temp_coeffs[15:0]};
            t2 = sx16(temp_coeffs[31:16]);
            t3 = sx16(temp_coeffs[47:32]);
            p1 = {112'b0, press_low[15:0]};
            p2 = sx16(press_low[31:16]);
            p3 = sx16(press_low[47:32]);
            p4 = sx16(press_low[63:48]);
            p5 = sx16(press_high[15:0]);
            p6 = sx16(press_high[31:16]);
            p7 = sx16(press_high[47:32]);
            p8 = sx16(press_high[63:48]);
            p9 = sx16(press_nine);

            va = (((adc_t >>> 3) - 2 * t1) * t2) >>> 11;
            d = (adc_t >>> 4) - t1;
            vb = (((d * d) >>> 12) * t3) >>> 14;
            tfine = clamp(va + vb, -(wide_t'(1) <<< 31), (wide_t'(1) <<< 31) - 1);
            tc = clamp((tfine * 5 + ROUND_HALF) >>> 8, -8388608, 8388607);

            va = tfine - TFINE_OFFSET;
            vb = va * va * p6;
            vb = vb + va * p5 * 131072;
            vb = vb + p4 * (wide_t'(1) <<< P4_SHIFT);
            va = ((va * va * p3) >>> 8) + va * p2 * 4096;
            va = mul_floor_sat((wide_t'(1) <<< ONE_SHIFT) + va, p1, 33);

            res.fine     = tfine[31:0];
            res.centi    = tc[23:0];
            res.press    = '0;
            res.press_ok = 1'b0;
            if (va != 0) begin
                num = (RAW_FULL - adc_p) * (wide_t'(1) <<< 31) - vb;
                neg = (num < 0) != (va < 0);
                un = num < 0 ? -num : num;
                ud = va < 0 ? -va : va;
                q1 = un / ud;
                r1 = un % ud;
                if (q1 > (128'd1 << 47))
                    mag = 128'd1 << 47;
                else
                    mag = q1 * PRESS_SCALE + (r1 * PRESS_SCALE) / ud;
                if (mag > (128'd1 << 47))
                    mag = 128'd1 << 47;
                pr = neg ? -$signed(mag) : $signed(mag);
                s = pr >>> 13;
                c9 = mul_floor_sat(p9 * s, s, 25);
                c8 = (p8 * pr) >>> 19;
                pr = ((pr + c9 + c8) >>> 8) + p7 * 16;
                pr = clamp(pr, 0, 128'hFFFF_FFFF);
                res.press    = pr[31:0];
                res.press_ok = 1'b1;
            end
            expected_q.push_back(res);
        endfunction

        function void check_result(logic [TFINE_W-1:0] fine, logic [TC_W-1:0] centi,
                                   logic [PRESS_W-1:0] press, logic press_ok);
            comp_result_t e;
            if (expected_q.size() == 0) begin
                $error("result transaction with no expected result pending");
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (fine !== e.fine) begin
                $error("fine_temperature expected %h actual %h", e.fine, fine);
                errors++;
            end
            if (centi !== e.centi) begin
                $error("temperature_centi expected %h actual %h", e.centi, centi);
                errors++;
            end
            if (press !== e.press) begin
                $error("pressure_q24_8 expected %h actual %h", e.press, press);
                errors++;
            end
            if (press_ok !== e.press_ok) begin
                $error("pressure_valid expected %b actual %b", e.press_ok, press_ok);
                errors++;
            end
        endfunction
    endclass

    localparam int CYCLE_LIMIT = 400000;

    logic                      aclk;
    logic                      aresetn;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [1:0]                cfg_index;
    logic [CFG_DATA_W-1:0]     cfg_data;
    logic                      s_valid;
    logic                      s_ready;
    logic [RAW_W-1:0]          s_raw_temperature;
    logic [RAW_W-1:0]          s_raw_pressure;
    logic                      m_valid;
    logic                      m_ready;
    logic signed [TFINE_W-1:0] m_fine_temperature;
    logic signed [TC_W-1:0]    m_temperature_centi;
    logic [PRESS_W-1:0]        m_pressure_q24_8;
    logic                      m_pressure_valid;

    comp_scoreboard sb = new();
    int  cycle_count = 0;
    int  burst_left = 0;
    bit  hold_request = 0;

    baro_temp_pressure_compensation_unit u_dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_raw_temperature   (s_raw_temperature),
        .s_raw_pressure      (s_raw_pressure),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_fine_temperature  (m_fine_temperature),
        .m_temperature_centi (m_temperature_centi),
        .m_pressure_q24_8    (m_pressure_q24_8),
        .m_pressure_valid    (m_pressure_valid)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("baro_temp_pressure_compensation_unit verification failed");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_fine_temperature, m_temperature_centi,
                            m_pressure_q24_8, m_pressure_valid);
    end

    // receiver stall pattern
    initial begin
        int mode;
        int len;
        forever begin
            if (hold_request) begin
                hold_request = 0;
                m_ready <= 1'b0;
                repeat (400) @(posedge aclk);
            end
            mode = $urandom_range(0, 3);
            len  = $urandom_range(5, 60);
            repeat (len) begin
                case (mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= 1'($urandom_range(0, 1));
                    2: m_ready <= ($urandom_range(0, 7) == 0);
                    default: m_ready <= ($urandom_range(0, 7) != 0);
                endcase
                @(posedge aclk);
            end
        end
    end

    task automatic send_reading(logic [RAW_W-1:0] raw_t, logic [RAW_W-1:0] raw_p);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 30);
        end
        s_valid           <= 1'b1;
        s_raw_temperature <= raw_t;
        s_raw_pressure    <= raw_p;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_reading(raw_t, raw_p);
        burst_left--;
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
    endtask

    task automatic write_register(bptc_reg_t idx, logic [63:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.set_register(idx, data);
    endtask

    task automatic load_coeffs(logic [47:0] tc, logic [63:0] pl, logic [63:0] ph,
                               logic [15:0] p9);
        wait_drained();
        write_register(REG_TEMP, {$urandom, $urandom});
        write_register(REG_TEMP, {16'h0, tc});
        write_register(REG_PLOW, pl);
        write_register(REG_PHIGH, ph);
        write_register(REG_PNINE, {$urandom, $urandom});
        write_register(REG_PNINE, {48'h0, p9});
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic random_readings(int count);
        logic [RAW_W-1:0] rt, rp;
        repeat (count) begin
            if ($urandom_range(0, 3) != 0) begin
                rt = RAW_W'($urandom_range(400000, 620000));
                rp = RAW_W'($urandom_range(200000, 700000));
            end else begin
                rt = RAW_W'($urandom);
                rp = RAW_W'($urandom);
            end
            send_reading(rt, rp);
        end
    endtask

    // realistic factory calibration
    localparam logic [47:0] TYP_T  = {16'hFC18, 16'd26435, 16'd27504};
    localparam logic [63:0] TYP_PL = {16'd2855, 16'd3024, 16'hD643, 16'd36477};
    localparam logic [63:0] TYP_PH = {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140};

    initial begin
        aresetn   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_TEMP;
        cfg_data  <= '0;
        s_valid   <= 1'b0;
        s_raw_temperature <= '0;
        s_raw_pressure    <= '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset coefficients give a zero divisor
        send_reading('0, '0);
        send_reading('1, '1);
        send_reading(20'h80000, 20'h7FFFF);

        load_coeffs(TYP_T, TYP_PL, TYP_PH, 16'd6000);
        send_reading(20'd519888, 20'd415148);
        send_reading('0, '0);
        send_reading('1, '1);
        send_reading('0, '1);
        send_reading('1, '0);
        send_reading(20'h55555, 20'hAAAAA);
        send_reading(20'hAAAAA, 20'h55555);
        send_reading(20'd524288, 20'd1);

        // zero divisor with realistic temperature
        load_coeffs(TYP_T, {TYP_PL[63:16], 16'h0}, TYP_PH, 16'd6000);
        send_reading(20'd519888, 20'd415148);
        send_reading('1, '0);

        load_coeffs('1, '1, '1, 16'hFFFF);
        send_reading('0, '0);
        send_reading('1, '1);
        send_reading(20'd519888, 20'd415148);

        load_coeffs({16'h8000, 16'h8000, 16'hFFFF}, {16'h7FFF, 16'h8000, 16'h7FFF, 16'h0001},
                    {16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000}, 16'h7FFF);
        send_reading('0, '1);
        send_reading('1, '0);
        send_reading(20'd400000, 20'd300000);

        load_coeffs(TYP_T, TYP_PL, TYP_PH, 16'd6000);
        hold_request = 1;
        random_readings(150);
        load_coeffs(48'({$urandom, $urandom}), {$urandom, $urandom}, {$urandom, $urandom},
                    16'($urandom));
        random_readings(110);
        load_coeffs(48'({$urandom, $urandom}), {$urandom, $urandom}, {$urandom, $urandom},
                    16'($urandom));
        random_readings(110);
        load_coeffs(TYP_T, {TYP_PL[63:16], 16'($urandom_range(1, 3))}, {$urandom, $urandom},
                    16'h8000);
        random_readings(110);
        load_coeffs('0, '0, '0, '0);
        random_readings(40);
        load_coeffs('1, '1, '1, 16'hFFFF);
        random_readings(100);
        load_coeffs(48'({$urandom, $urandom}), {$urandom, $urandom}, {$urandom, $urandom},
                    16'($urandom));
        hold_request = 1;
        random_readings(110);

        wait_drained();
        if (sb.errors == 0)
            $display("baro_temp_pressure_compensation_unit verification clean");
        else
            $display("baro_temp_pressure_compensation_unit verification failed");
        $finish;
    end

endmodule
